### rtl/itra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itra_pkg
// Shared types, constants and helpers for the integer to radix ASCII converter.
// ----------------------------------------------------------------------------
package itra_pkg;

  // Default word width of the converted value.
  localparam int unsigned WORD_BITS_DEF = 64;

  // Fixed widths of the stream fields.
  localparam int unsigned NUMBER_W = 64;
  localparam int unsigned RADIX_W  = 8;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned IN_TDATA_W  = ((NUMBER_W + RADIX_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((CHAR_W + 7) / 8) * 8;

  // Bits of the dividend consumed per divider cycle.
  localparam int unsigned CHUNK_BITS = 8;

  // Base limits and digit width.
  localparam int unsigned BASE_W   = 5;
  localparam int unsigned DIGIT_W  = 4;
  localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);
  localparam logic [BASE_W-1:0] BASE_DEC = BASE_W'(10);

  // ASCII codes.
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_LOW_A = 8'h61;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2d;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_STORE,
    ST_SIGN,
    ST_READ,
    ST_SHOW
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a new input transaction
    logic div_step;  // run one chunk of the divide pass
    logic store;     // write the remainder digit and start a new pass
    logic rd;        // read the next digit, most significant first
    logic sel_sign;  // drive the minus sign onto the output
  } itra_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic chunk_last;  // this divide cycle handles the final chunk
    logic quot_zero;   // quotient of the finished pass is zero
    logic neg_sign;    // a minus sign is to be emitted
    logic cnt_zero;    // no digits remain to be read
  } itra_stat_t;

  // Map a digit value to its lower-case ASCII character.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d > DIGIT_W'(9)) begin
      c = ASCII_LOW_A + CHAR_W'(d - DIGIT_W'(10));
    end else begin
      c = ASCII_ZERO + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/integer_to_radix_ascii.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_radix_ascii
// Converts a signed integer to its ASCII digit string in a base from 2 to 16.
// ----------------------------------------------------------------------------
// Each input transaction carries a two's complement value (low WORD_BITS bits
// used) and a base, clamped to 2..16. The block returns one output transaction
// per character, most significant digit first, lower-case letters above 9,
// with tlast on the final character. A leading '-' appears only for negative
// values in base 10; other bases print the magnitude. One value is converted
// at a time. Digits are produced by repeated division by the base in a divider
// that consumes 8 bits of the magnitude per cycle; after each divide pass the
// remainder is stored as the next digit. A leading minus sign is offered once
// all digits are stored, and once it is taken the output stays empty while
// the first digit is read. The digits then leave at one per cycle while the
// output is ready, and the next value is taken in the cycle after the last
// character. Worst case is base 2 with 64 digits for a 64-bit word.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii #(
  parameter int unsigned WORD_BITS = itra_pkg::WORD_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // tdata: number [63:0], radix [71:64]
  input  wire logic [itra_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: character [7:0]
  output logic [itra_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                  m_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready
);
  import itra_pkg::*;

  itra_cmd_t         cmd;
  itra_stat_t        stat;
  logic [CHAR_W-1:0] character;

  // Sequencing of divide passes and output transactions.
  itra_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  // Divider, digit memory and character mapping.
  itra_dpath #(
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .number_i    (s_axis_tdata[NUMBER_W-1:0]),
    .radix_i     (s_axis_tdata[NUMBER_W +: RADIX_W]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .character_o (character)
  );

  assign m_axis_tdata = OUT_TDATA_W'(character);

endmodule
`default_nettype wire

### rtl/itra_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itra_ctrl
// Controller: sequences the divide passes, digit stores and character output.
// ----------------------------------------------------------------------------
module itra_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic                    m_axis_tlast,
  input  wire itra_pkg::itra_stat_t stat_i,
  output itra_pkg::itra_cmd_t     cmd_o
);
  import itra_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    m_axis_tlast  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.chunk_last) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        if (!stat_i.quot_zero) begin
          state_d = ST_DIVIDE;
        end else if (stat_i.neg_sign) begin
          state_d = ST_SIGN;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_SIGN: begin
        m_axis_tvalid  = 1'b1;
        cmd_o.sel_sign = 1'b1;
        if (m_axis_tready) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_SHOW;
      end
      ST_SHOW: begin
        m_axis_tvalid = 1'b1;
        m_axis_tlast  = stat_i.cnt_zero;
        if (m_axis_tready) begin
          if (stat_i.cnt_zero) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.rd = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/itra_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// itra_dpath
// Datapath: magnitude capture, chunked divide by the base, digit memory.
// ----------------------------------------------------------------------------
module itra_dpath #(
  parameter int unsigned WORD_BITS = itra_pkg::WORD_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [itra_pkg::NUMBER_W-1:0] number_i,
  input  wire logic [itra_pkg::RADIX_W-1:0]  radix_i,
  input  wire itra_pkg::itra_cmd_t           cmd_i,
  output itra_pkg::itra_stat_t               stat_o,
  output logic [itra_pkg::CHAR_W-1:0]        character_o
);
  import itra_pkg::*;

  localparam int unsigned CHUNKS = (WORD_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int unsigned PAD_W  = CHUNKS * CHUNK_BITS;
  localparam int unsigned CHK_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int unsigned CNT_W  = $clog2(WORD_BITS + 1);
  localparam int unsigned ADDR_W = $clog2(WORD_BITS);

  logic [PAD_W-1:0]   div_q, div_d;
  logic [DIGIT_W-1:0] rem_q, rem_d;
  logic [BASE_W-1:0]  base_q, base_d;
  logic               neg10_q, neg10_d;
  logic [CHK_W-1:0]   chk_q, chk_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [DIGIT_W-1:0] rdata_q;
  logic [DIGIT_W-1:0] mem_q [WORD_BITS];

  logic [WORD_BITS-1:0]  raw;
  logic [WORD_BITS-1:0]  mag;
  logic                  neg;
  logic [CHUNK_BITS-1:0] top_byte;
  logic [CHUNK_BITS-1:0] quot_byte;
  logic [DIGIT_W-1:0]    rem_step;
  logic [CNT_W-1:0]      cnt_dec;

  // Input capture: magnitude and clamped base.
  always_comb begin
    raw = number_i[WORD_BITS-1:0];
    neg = raw[WORD_BITS-1];
    mag = neg ? (~raw + WORD_BITS'(1)) : raw;
    if (radix_i > RADIX_W'(BASE_MAX)) begin
      base_d = BASE_MAX;
    end else if (radix_i < RADIX_W'(BASE_MIN)) begin
      base_d = BASE_MIN;
    end else begin
      base_d = radix_i[BASE_W-1:0];
    end
  end

  // One chunk of long division: eight restoring steps on a small remainder.
  always_comb begin
    logic [BASE_W-1:0] r;
    top_byte = div_q[PAD_W-1 -: CHUNK_BITS];
    r = BASE_W'(rem_q);
    for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
      r = {r[DIGIT_W-1:0], top_byte[i]};
      if (r >= base_q) begin
        r = r - base_q;
        quot_byte[i] = 1'b1;
      end else begin
        quot_byte[i] = 1'b0;
      end
    end
    rem_step = r[DIGIT_W-1:0];
  end

  assign cnt_dec = cnt_q - CNT_W'(1);

  // Next values of the working registers.
  always_comb begin
    div_d   = div_q;
    rem_d   = rem_q;
    neg10_d = neg10_q;
    chk_d   = chk_q;
    cnt_d   = cnt_q;
    if (cmd_i.load) begin
      div_d   = PAD_W'(mag);
      rem_d   = '0;
      neg10_d = neg && (base_d == BASE_DEC);
      chk_d   = '0;
      cnt_d   = '0;
    end else if (cmd_i.div_step) begin
      div_d = (div_q << CHUNK_BITS) | PAD_W'(quot_byte);
      rem_d = rem_step;
      chk_d = chk_q + CHK_W'(1);
    end else if (cmd_i.store) begin
      rem_d = '0;
      chk_d = '0;
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.rd) begin
      cnt_d = cnt_dec;
    end
  end

  // Control and working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q   <= '0;
      cnt_q   <= '0;
      neg10_q <= 1'b0;
    end else begin
      chk_q   <= chk_d;
      cnt_q   <= cnt_d;
      neg10_q <= neg10_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    if (cmd_i.load) begin
      base_q <= base_d;
    end
  end

  // Digit memory: least significant digit at the lowest address.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem_q[cnt_q[ADDR_W-1:0]] <= rem_q;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[cnt_dec[ADDR_W-1:0]];
    end
  end

  // Status and output character.
  always_comb begin
    stat_o.chunk_last = (chk_q == CHK_W'(CHUNKS - 1));
    stat_o.quot_zero  = (div_q == '0);
    stat_o.neg_sign   = neg10_q;
    stat_o.cnt_zero   = (cnt_q == '0);
    character_o = cmd_i.sel_sign ? ASCII_MINUS : digit_char(rdata_q);
  end

endmodule
`default_nettype wire
